[design/cph_pkg.sv]
package cph_pkg;

	localparam int MSG_BYTES = 15;
	localparam int MSG_BITS = 8 * MSG_BYTES;
	localparam logic [7:0] CRC_POLY = 8'h07;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] BYTE_CMD = 8'hC0;
	localparam logic [7:0] BYTE_DATA = 8'hD0;
	localparam logic [7:0] BYTE_RESEND = 8'hEF;
	localparam logic [7:0] BYTE_REPORT = 8'hE0;
	localparam logic [7:0] BYTE_REPORT_SUB = 8'h10;

	localparam logic [7:0] SUB_PING = 8'h01;
	localparam logic [7:0] SUB_STATUS = 8'h10;
	localparam logic [7:0] SUB_PUNCH = 8'h11;
	localparam logic [7:0] SUB_LINK_SER = 8'h20;
	localparam logic [7:0] SUB_LINK_WIFI = 8'h21;
	localparam logic [7:0] SUB_SER_OFF = 8'h30;
	localparam logic [7:0] SUB_WIFI_OFF = 8'h31;
	localparam logic [7:0] SUB_DATA_START = 8'hA0;
	localparam logic [7:0] SUB_DATA_END = 8'hA1;

	localparam logic [7:0] COLUMN_MAX = 8'd29;

	localparam logic [7:0] ST_IDLE = 8'h10;
	localparam logic [7:0] ST_DATA = 8'h01;
	localparam logic [7:0] ST_PUNCH = 8'h11;

	typedef enum logic [2:0] {
		ACT_SERIAL = 3'd0,
		ACT_WIFI = 3'd1,
		ACT_SET_STATUS = 3'd2,
		ACT_DIS_SERIAL = 3'd3,
		ACT_DIS_WIFI = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		HEAD_CMD,
		HEAD_DATA,
		HEAD_RESEND,
		HEAD_OTHER
	} head_t;

	typedef enum logic [3:0] {
		CMD_PING,
		CMD_STATUS,
		CMD_PUNCH,
		CMD_LINK_SER,
		CMD_LINK_WIFI,
		CMD_SER_OFF,
		CMD_WIFI_OFF,
		CMD_DATA_START,
		CMD_DATA_END,
		CMD_OTHER
	} cmd_t;

	typedef enum logic [3:0] {
		K_CRC = 4'd0,
		K_OK = 4'd1,
		K_SER_OFF = 4'd2,
		K_WIFI_OFF = 4'd3,
		K_UNKNOWN = 4'd4,
		K_STATUS = 4'd5,
		K_RANGE = 4'd6,
		K_DATA_OFF = 4'd7,
		K_NO_HOLES = 4'd8
	} resp_kind_t;

	typedef struct packed {
		act_t act;
		logic crc_ok;
		head_t head;
		cmd_t cmd;
		logic col_ok;
		logic [4:0] column;
		logic [63:0] position;
		logic [7:0] status;
	} entry_t;

	typedef logic [MSG_BITS-1:0][7:0] crc_cols_t;

	// CRC contribution of a message with only bit p set (bit MSG_BITS-1 goes in first)
	function automatic logic [7:0] crc8_col(int p);
		logic [7:0] c;
		logic fb;
		c = 8'h00;
		for (int i = MSG_BITS - 1; i >= 0; i--) begin
			fb = c[7] ^ (i == p);
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic crc_cols_t crc8_cols();
		crc_cols_t t;
		for (int p = 0; p < MSG_BITS; p++) begin
			t[p] = crc8_col(p);
		end
		return t;
	endfunction

	localparam crc_cols_t CRC_COLS = crc8_cols();

	// CRC is linear with zero init: XOR the columns of the set bits
	function automatic logic [7:0] crc8_msg(logic [MSG_BITS-1:0] m);
		logic [7:0] c;
		c = 8'h00;
		for (int p = 0; p < MSG_BITS; p++) begin
			c = c ^ (m[p] ? CRC_COLS[p] : 8'h00);
		end
		return c;
	endfunction

	function automatic logic [7:0] report_crc(logic [7:0] status);
		return crc8_msg({BYTE_REPORT, BYTE_REPORT_SUB, status, {(MSG_BITS - 24){1'b0}}});
	endfunction

endpackage

[design/cph_front.sv]
module cph_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [7:0]           head_byte,
	input  logic [7:0]           sub_byte,
	input  logic [63:0]          position_bytes,
	input  logic [39:0]          tail_bytes,
	input  logic [7:0]           check_byte,
	input  logic [7:0]           new_status,
	input  logic                 queue_full,
	output logic                 push_valid,
	output cph_pkg::entry_t      push_entry
);

	logic [cph_pkg::MSG_BITS-1:0] msg;
	logic keep;
	cph_pkg::entry_t entry;
	logic valid_s1;
	cph_pkg::entry_t entry_s1;

	always_comb begin
		msg = '0;
		msg[cph_pkg::MSG_BITS-1 -: 8] = head_byte;
		msg[cph_pkg::MSG_BITS-9 -: 8] = sub_byte;
		for (int i = 0; i < 8; i++) begin
			msg[cph_pkg::MSG_BITS-17-8*i -: 8] = position_bytes[8*i +: 8];
		end
		for (int i = 0; i < 5; i++) begin
			msg[39-8*i -: 8] = tail_bytes[8*i +: 8];
		end
	end

	always_comb begin
		case (cph_pkg::act_t'(action))
			cph_pkg::ACT_SERIAL, cph_pkg::ACT_WIFI, cph_pkg::ACT_SET_STATUS,
			cph_pkg::ACT_DIS_SERIAL, cph_pkg::ACT_DIS_WIFI: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		entry.act = cph_pkg::act_t'(action);
		entry.crc_ok = (cph_pkg::crc8_msg(msg) == check_byte);
		entry.col_ok = (sub_byte <= cph_pkg::COLUMN_MAX);
		entry.column = sub_byte[4:0];
		entry.position = position_bytes;
		entry.status = new_status;
		case (head_byte)
			cph_pkg::BYTE_CMD: entry.head = cph_pkg::HEAD_CMD;
			cph_pkg::BYTE_DATA: entry.head = cph_pkg::HEAD_DATA;
			cph_pkg::BYTE_RESEND: entry.head = cph_pkg::HEAD_RESEND;
			default: entry.head = cph_pkg::HEAD_OTHER;
		endcase
		case (sub_byte)
			cph_pkg::SUB_PING: entry.cmd = cph_pkg::CMD_PING;
			cph_pkg::SUB_STATUS: entry.cmd = cph_pkg::CMD_STATUS;
			cph_pkg::SUB_PUNCH: entry.cmd = cph_pkg::CMD_PUNCH;
			cph_pkg::SUB_LINK_SER: entry.cmd = cph_pkg::CMD_LINK_SER;
			cph_pkg::SUB_LINK_WIFI: entry.cmd = cph_pkg::CMD_LINK_WIFI;
			cph_pkg::SUB_SER_OFF: entry.cmd = cph_pkg::CMD_SER_OFF;
			cph_pkg::SUB_WIFI_OFF: entry.cmd = cph_pkg::CMD_WIFI_OFF;
			cph_pkg::SUB_DATA_START: entry.cmd = cph_pkg::CMD_DATA_START;
			cph_pkg::SUB_DATA_END: entry.cmd = cph_pkg::CMD_DATA_END;
			default: entry.cmd = cph_pkg::CMD_OTHER;
		endcase
	end

	assign in_stall = valid_s1 && queue_full;
	assign push_valid = valid_s1 && !queue_full;
	assign push_entry = entry_s1;

	// drop unused actions here; they leave no trace
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			entry_s1 <= entry;
		end
	end

endmodule

[design/cph_queue.sv]
module cph_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cph_pkg::entry_t      push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output cph_pkg::entry_t      pop_entry
);

	cph_pkg::entry_t mem_q [cph_pkg::QUEUE_DEPTH];
	logic [cph_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [cph_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [cph_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full = (count_q == cph_pkg::QUEUE_CNT_W'(cph_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + cph_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cph_pkg::QUEUE_PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + cph_pkg::QUEUE_CNT_W'(1);
				2'b01: count_q <= count_q - cph_pkg::QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[design/cph_back.sv]
module cph_back #(
	parameter logic [10:0] HOLE_CAP = 11'd1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cph_pkg::entry_t      q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           response_kind,
	output logic [7:0]           report_status,
	output logic [7:0]           report_check,
	output logic                 hole_valid,
	output logic [4:0]           hole_column,
	output logic [63:0]          hole_position,
	output logic                 punch_start,
	output logic [10:0]          punch_hole_total
);

	logic ser_q;
	logic wifi_q;
	logic [7:0] status_q;
	logic [10:0] holes_q;
	cph_pkg::resp_kind_t saved_kind_q;
	logic [7:0] saved_status_q;
	logic [7:0] saved_check_q;
	logic out_valid_q;

	logic take;
	logic ser_n;
	logic wifi_n;
	logic [7:0] status_n;
	logic [10:0] holes_n;
	logic res;
	logic save;
	logic rep;
	logic hole;
	logic punch;
	logic resend;
	logic is_serial;
	cph_pkg::resp_kind_t kind;
	logic [7:0] rep_status;
	logic [7:0] rep_check;

	assign take = q_valid && (!out_valid_q || !out_stall);
	assign q_pop = take;
	assign out_valid = out_valid_q;
	assign is_serial = (q_entry.act == cph_pkg::ACT_SERIAL);

	always_comb begin
		ser_n = ser_q;
		wifi_n = wifi_q;
		status_n = status_q;
		holes_n = holes_q;
		res = 1'b0;
		save = 1'b0;
		rep = 1'b0;
		hole = 1'b0;
		punch = 1'b0;
		resend = 1'b0;
		kind = cph_pkg::K_CRC;
		if (take) begin
			case (q_entry.act)
				cph_pkg::ACT_SET_STATUS: status_n = q_entry.status;
				cph_pkg::ACT_DIS_SERIAL: ser_n = 1'b0;
				cph_pkg::ACT_DIS_WIFI: wifi_n = 1'b0;
				cph_pkg::ACT_SERIAL, cph_pkg::ACT_WIFI: begin
					res = 1'b1;
					if (!q_entry.crc_ok) begin
						kind = cph_pkg::K_CRC;
					end else if (is_serial && q_entry.head == cph_pkg::HEAD_CMD
						&& q_entry.cmd == cph_pkg::CMD_LINK_SER) begin
						ser_n = 1'b1;
						wifi_n = 1'b0;
						kind = cph_pkg::K_OK;
					end else if (is_serial && !ser_q) begin
						kind = cph_pkg::K_SER_OFF;
					end else if (!is_serial && !ser_q && q_entry.head == cph_pkg::HEAD_CMD
						&& q_entry.cmd == cph_pkg::CMD_LINK_WIFI) begin
						wifi_n = 1'b1;
						kind = cph_pkg::K_OK;
					end else if (!is_serial && !wifi_q) begin
						kind = cph_pkg::K_WIFI_OFF;
					end else begin
						case (q_entry.head)
							cph_pkg::HEAD_CMD: begin
								case (q_entry.cmd)
									cph_pkg::CMD_PING: kind = cph_pkg::K_OK;
									cph_pkg::CMD_STATUS: rep = 1'b1;
									cph_pkg::CMD_PUNCH: begin
										if (status_q == cph_pkg::ST_IDLE && holes_q == '0) begin
											kind = cph_pkg::K_NO_HOLES;
											save = 1'b1;
										end else begin
											if (status_q == cph_pkg::ST_IDLE) begin
												status_n = cph_pkg::ST_PUNCH;
												punch = 1'b1;
											end
											rep = 1'b1;
										end
									end
									cph_pkg::CMD_SER_OFF: begin
										ser_n = 1'b0;
										kind = cph_pkg::K_OK;
									end
									cph_pkg::CMD_WIFI_OFF: begin
										wifi_n = 1'b0;
										kind = cph_pkg::K_OK;
									end
									cph_pkg::CMD_DATA_START: begin
										if (status_q == cph_pkg::ST_IDLE) begin
											status_n = cph_pkg::ST_DATA;
										end
										rep = 1'b1;
									end
									cph_pkg::CMD_DATA_END: begin
										if (status_q == cph_pkg::ST_DATA) begin
											status_n = cph_pkg::ST_IDLE;
										end
										rep = 1'b1;
									end
									default: begin
										kind = cph_pkg::K_UNKNOWN;
										save = 1'b1;
									end
								endcase
							end
							cph_pkg::HEAD_DATA: begin
								save = 1'b1;
								if (status_q != cph_pkg::ST_DATA) begin
									kind = cph_pkg::K_DATA_OFF;
								end else if (!q_entry.col_ok) begin
									kind = cph_pkg::K_RANGE;
								end else begin
									// saturate: a hole past the cap still counts as accepted
									if (holes_q < HOLE_CAP) begin
										holes_n = holes_q + 11'd1;
									end
									hole = 1'b1;
									kind = cph_pkg::K_OK;
								end
							end
							cph_pkg::HEAD_RESEND: resend = 1'b1;
							default: begin
								kind = cph_pkg::K_UNKNOWN;
								save = 1'b1;
							end
						endcase
					end
					if (rep) begin
						kind = cph_pkg::K_STATUS;
						save = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign rep_status = rep ? status_n : 8'h00;
	assign rep_check = rep ? cph_pkg::report_crc(status_n) : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_q <= 1'b0;
			wifi_q <= 1'b0;
			status_q <= cph_pkg::ST_IDLE;
			holes_q <= '0;
			saved_kind_q <= cph_pkg::K_CRC;
			saved_status_q <= 8'h00;
			saved_check_q <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			ser_q <= ser_n;
			wifi_q <= wifi_n;
			status_q <= status_n;
			holes_q <= holes_n;
			if (save) begin
				saved_kind_q <= kind;
				saved_status_q <= rep_status;
				saved_check_q <= rep_check;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= take && res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res) begin
			response_kind <= resend ? saved_kind_q : kind;
			report_status <= resend ? saved_status_q : rep_status;
			report_check <= resend ? saved_check_q : rep_check;
			hole_valid <= hole;
			hole_column <= hole ? q_entry.column : 5'd0;
			hole_position <= hole ? q_entry.position : 64'd0;
			punch_start <= punch;
			punch_hole_total <= punch ? holes_q : 11'd0;
		end
	end

endmodule

[design/crc_checked_command_packet_handler_core.sv]
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  action, head_byte, sub_byte, position_bytes,
//                                          tail_bytes, check_byte, new_status
// result   out        out_valid / out_stall response_kind, report_status, report_check,
//                                          hole_valid, hole_column, hole_position,
//                                          punch_start, punch_hole_total
//
// One item per cycle sustained while out_stall stays low; a packet's result passes through
// the CRC and decode register, the two-entry queue, and the execute and output register.
// Link, status and hole-count updates occur in the execute stage, one item per unstalled cycle.
// Reset is asynchronous and clears control state; no clearing pass is needed.
// A stalled output holds the back end; the queue then absorbs up to two items before
// in_stall rises.
module crc_checked_command_packet_handler_core #(
	parameter int MAX_HOLES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [2:0]   action,
	input  logic [7:0]   head_byte,
	input  logic [7:0]   sub_byte,
	input  logic [63:0]  position_bytes,
	input  logic [39:0]  tail_bytes,
	input  logic [7:0]   check_byte,
	input  logic [7:0]   new_status,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [3:0]   response_kind,
	output logic [7:0]   report_status,
	output logic [7:0]   report_check,
	output logic         hole_valid,
	output logic [4:0]   hole_column,
	output logic [63:0]  hole_position,
	output logic         punch_start,
	output logic [10:0]  punch_hole_total
);

	localparam logic [10:0] HOLE_CAP = (MAX_HOLES > 2047) ? 11'd2047 : 11'(MAX_HOLES);

	logic push_valid;
	cph_pkg::entry_t push_entry;
	logic queue_full;
	logic q_valid;
	logic q_pop;
	cph_pkg::entry_t q_entry;

	cph_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.head_byte      (head_byte),
		.sub_byte       (sub_byte),
		.position_bytes (position_bytes),
		.tail_bytes     (tail_bytes),
		.check_byte     (check_byte),
		.new_status     (new_status),
		.queue_full     (queue_full),
		.push_valid     (push_valid),
		.push_entry     (push_entry)
	);

	cph_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (q_pop),
		.not_empty  (q_valid),
		.pop_entry  (q_entry)
	);

	cph_back #(
		.HOLE_CAP (HOLE_CAP)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_entry          (q_entry),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.response_kind    (response_kind),
		.report_status    (report_status),
		.report_check     (report_check),
		.hole_valid       (hole_valid),
		.hole_column      (hole_column),
		.hole_position    (hole_position),
		.punch_start      (punch_start),
		.punch_hole_total (punch_hole_total)
	);

`ifndef SYNTHESIS
	a_status_check: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response_kind == cph_pkg::K_STATUS
		|-> report_check == cph_pkg::report_crc(report_status))
		else $error("status report carries a wrong check byte");

	a_hole_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hole_valid
		|-> response_kind == cph_pkg::K_OK && {3'b000, hole_column} <= cph_pkg::COLUMN_MAX
			&& !punch_start)
		else $error("accepted hole with a bad response");

	a_punch_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && punch_start
		|-> response_kind == cph_pkg::K_STATUS && report_status == cph_pkg::ST_PUNCH
			&& punch_hole_total != 11'd0 && punch_hole_total <= HOLE_CAP)
		else $error("punch start without holes or punching status");
`endif

endmodule
